FILE: hdl/heightmap_triangle_bilinear_sampler_macros.svh
// Assertion helpers used by the sampler top module.
`ifndef HEIGHTMAP_TRIANGLE_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_BILINEAR_SAMPLER_MACROS_SVH

// cond must never hold at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed");

// a implies b in the same cycle
`define ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

FILE: hdl/hmtbs_pkg.sv
package hmtbs_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_LENGTH = 512;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_LENGTH = 2'd1,
        REG_INV_X      = 2'd2,
        REG_INV_Z      = 2'd3
    } t_reg_idx;

    // cell info carried alongside the corner reads
    typedef struct packed {
        logic [7:0] fx;
        logic [7:0] fz;
        logic       rev;
        logic       in_range;
        logic       x0p;
        logic       x1p;
        logic       z0p;
        logic       z1p;
    } t_meta;

endpackage

FILE: hdl/heightmap_triangle_bilinear_sampler.sv
// A query is registered through every pipeline stage to the output; loads give no result.
// One item per cycle unless i_ready stalls; loads and queries mixed freely.
// Four banks split by column and row parity, one read port each, feed the
// four corners of a cell together; a load writes one bank in the same stage.
// Reset (synchronous, active low) clears pipeline control and config registers;
// the height store is not cleared and needs no clearing pass.
`include "heightmap_triangle_bilinear_sampler_macros.svh"
module heightmap_triangle_bilinear_sampler #(
    parameter int MAX_WIDTH  = hmtbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_LENGTH = hmtbs_pkg::DEF_MAX_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [8:0]         i_load_col,
    input  logic [8:0]         i_load_row,
    input  logic [7:0]         i_pixel,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_z,
    input  logic               i_reverse_quad,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_height,
    output logic               o_in_range
);
    import hmtbs_pkg::*;

    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int LW    = $clog2(MAX_LENGTH + 1);
    localparam int HW    = (MAX_WIDTH + 1) / 2;
    localparam int HL    = (MAX_LENGTH + 1) / 2;
    localparam int BDEP  = HW * HL;
    localparam int AW    = (BDEP > 1) ? $clog2(BDEP) : 1;

    logic [9:0]  r_map_width, r_map_length;
    logic [23:0] r_inv_x, r_inv_z;
    logic [DW-1:0] w_sat;
    logic [LW-1:0] l_sat;

    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic e1, e2, e3, e4, e_o;

    logic                q2;
    logic [3:0]          req_we;
    logic [AW-1:0]       waddr;
    logic [7:0]          wdata;
    logic [3:0][AW-1:0]  raddr;
    t_meta               meta2;
    logic [3:0]          bank_we, bank_re;
    logic [3:0][7:0]     rdata;
    t_reg_idx            widx;

    assign widx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 10'd512;
            r_map_length <= 10'd512;
            r_inv_x      <= 24'd65536;
            r_inv_z      <= 24'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_MAP_WIDTH:  r_map_width  <= pwdata[9:0];
                REG_MAP_LENGTH: r_map_length <= pwdata[9:0];
                REG_INV_X:      r_inv_x      <= pwdata[23:0];
                REG_INV_Z:      r_inv_z      <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_MAP_WIDTH:  prdata = {22'd0, r_map_width};
            REG_MAP_LENGTH: prdata = {22'd0, r_map_length};
            REG_INV_X:      prdata = {8'd0, r_inv_x};
            REG_INV_Z:      prdata = {8'd0, r_inv_z};
            default:        prdata = 32'd0;
        endcase
    end

    // dimensions in use, saturated to [2, max]
    always_comb begin
        if (r_map_width < 10'd2) begin
            w_sat = DW'(2);
        end else if (32'(r_map_width) > 32'(MAX_WIDTH)) begin
            w_sat = DW'(MAX_WIDTH);
        end else begin
            w_sat = DW'(r_map_width);
        end
        if (r_map_length < 10'd2) begin
            l_sat = LW'(2);
        end else if (32'(r_map_length) > 32'(MAX_LENGTH)) begin
            l_sat = LW'(MAX_LENGTH);
        end else begin
            l_sat = LW'(r_map_length);
        end
    end

    // each stage moves when the one after it is empty or moving
    always_comb begin
        e_o = !r_vo || i_ready;
        e4  = !r_v4 || e_o;
        e3  = !r_v3 || e4;
        e2  = !r_v2 || e3;
        e1  = !r_v1 || e2;
    end
    assign o_ready = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (e1)  r_v1 <= i_valid;
            if (e2)  r_v2 <= r_v1;
            if (e3)  r_v3 <= r_v2 && q2;
            if (e4)  r_v4 <= r_v3;
            if (e_o) r_vo <= r_v4;
        end
    end

    hmtbs_grid #(
        .MAX_WIDTH (MAX_WIDTH),
        .DW        (DW),
        .LW        (LW),
        .AW        (AW)
    ) u_grid (
        .i_clk         (i_clk),
        .i_en1         (e1),
        .i_en2         (e2),
        .i_cmd         (i_cmd),
        .i_load_col    (i_load_col),
        .i_load_row    (i_load_row),
        .i_pixel       (i_pixel),
        .i_world_x     (i_world_x),
        .i_world_z     (i_world_z),
        .i_reverse_quad(i_reverse_quad),
        .i_w           (w_sat),
        .i_l           (l_sat),
        .i_inv_x       (r_inv_x),
        .i_inv_z       (r_inv_z),
        .o_query       (q2),
        .o_we          (req_we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .o_meta        (meta2)
    );

    assign bank_we = (e3 && r_v2) ? req_we : 4'b0000;
    assign bank_re = (e3 && r_v2 && q2 && meta2.in_range) ? 4'b1111 : 4'b0000;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        hmtbs_ram #(
            .WIDTH(8),
            .DEPTH(BDEP),
            .AW   (AW)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (bank_we[b]),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_re   (bank_re[b]),
            .i_raddr(raddr[b]),
            .o_rdata(rdata[b])
        );
    end

    hmtbs_blend u_blend (
        .i_clk     (i_clk),
        .i_en3     (e3),
        .i_en4     (e4),
        .i_eno     (e_o),
        .i_meta    (meta2),
        .i_rdata   (rdata),
        .o_height  (o_height),
        .o_in_range(o_in_range)
    );

    assign o_valid = r_vo;

    `ASSERT_IMPLY(a_oob_zero, o_valid && !o_in_range, o_height == 16'd0)
    `ASSERT_IMPLY(a_one_write, 1'b1, $onehot0(bank_we))
    `ASSERT_NEVER(a_rw_excl, (|bank_we) && (|bank_re))
endmodule

FILE: hdl/hmtbs_ram.sv
module hmtbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/hmtbs_grid.sv
module hmtbs_grid #(
    parameter int MAX_WIDTH  = 512,
    parameter int DW         = 10,
    parameter int LW         = 10,
    parameter int AW         = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en1,
    input  logic                  i_en2,
    input  logic                  i_cmd,
    input  logic [8:0]            i_load_col,
    input  logic [8:0]            i_load_row,
    input  logic [7:0]            i_pixel,
    input  logic signed [31:0]    i_world_x,
    input  logic signed [31:0]    i_world_z,
    input  logic                  i_reverse_quad,
    input  logic [DW-1:0]         i_w,
    input  logic [LW-1:0]         i_l,
    input  logic [23:0]           i_inv_x,
    input  logic [23:0]           i_inv_z,
    output logic                  o_query,
    output logic [3:0]            o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [7:0]            o_wdata,
    output logic [3:0][AW-1:0]    o_raddr,
    output hmtbs_pkg::t_meta      o_meta
);
    import hmtbs_pkg::*;

    localparam int HW = (MAX_WIDTH + 1) / 2;

    logic               r_cmd1, r_rev1;
    logic [8:0]         r_col1, r_row1;
    logic [7:0]         r_pix1;
    logic signed [31:0] r_x1, r_z1;

    logic               r_cmd2, r_rev2;
    logic [8:0]         r_col2, r_row2;
    logic [7:0]         r_pix2;
    logic signed [56:0] r_px2, r_pz2;
    logic signed [56:0] n_px2, n_pz2;

    logic [31:0] w32, l32, srow, x0, x1, z0, z1;
    logic [32:0] cellx, cellz;
    logic        inr, ld_ok;
    logic [1:0]  wbank;

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_cmd1 <= i_cmd;
            r_rev1 <= i_reverse_quad;
            r_col1 <= i_load_col;
            r_row1 <= i_load_row;
            r_pix1 <= i_pixel;
            r_x1   <= i_world_x;
            r_z1   <= i_world_z;
        end
        if (i_en2) begin
            r_cmd2 <= r_cmd1;
            r_rev2 <= r_rev1;
            r_col2 <= r_col1;
            r_row2 <= r_row1;
            r_pix2 <= r_pix1;
            r_px2  <= n_px2;
            r_pz2  <= n_pz2;
        end
    end

    // world Q23.8 times Q8.16 gives grid in Q.24
    always_comb begin
        n_px2 = r_x1 * $signed({1'b0, i_inv_x});
        n_pz2 = r_z1 * $signed({1'b0, i_inv_z});
    end

    always_comb begin
        w32   = 32'(i_w);
        l32   = 32'(i_l);
        cellx = r_px2[56:24];
        cellz = r_pz2[56:24];
        inr   = !r_px2[56] && !r_pz2[56] && (cellx < 33'(w32)) && (cellz < 33'(l32));
        x0    = cellx[31:0];
        z0    = cellz[31:0];
        x1    = (x0 + 32'd1 < w32) ? x0 + 32'd1 : w32 - 32'd1;
        z1    = (z0 + 32'd1 < l32) ? z0 + 32'd1 : l32 - 32'd1;

        for (int b = 0; b < 4; b++) begin
            logic [31:0] ch, rh;
            ch = ((x0[0] == b[0]) ? x0 : x1) >> 1;
            rh = ((z0[0] == b[1]) ? z0 : z1) >> 1;
            o_raddr[b] = AW'(rh * 32'(HW) + ch);
        end

        o_meta.fx       = r_px2[23:16];
        o_meta.fz       = r_pz2[23:16];
        o_meta.rev      = r_rev2;
        o_meta.in_range = inr;
        o_meta.x0p      = x0[0];
        o_meta.x1p      = x1[0];
        o_meta.z0p      = z0[0];
        o_meta.z1p      = z1[0];
        o_query         = r_cmd2;

        // loads land vertically flipped
        ld_ok   = !r_cmd2 && (32'(r_col2) < w32) && (32'(r_row2) < l32);
        srow    = l32 - 32'd1 - 32'(r_row2);
        wbank   = {srow[0], r_col2[0]};
        o_we    = ld_ok ? (4'b0001 << wbank) : 4'b0000;
        o_waddr = AW'((srow >> 1) * 32'(HW) + 32'(r_col2 >> 1));
        o_wdata = r_pix2;
    end
endmodule

FILE: hdl/hmtbs_blend.sv
module hmtbs_blend (
    input  logic              i_clk,
    input  logic              i_en3,
    input  logic              i_en4,
    input  logic              i_eno,
    input  hmtbs_pkg::t_meta  i_meta,
    input  logic [3:0][7:0]   i_rdata,
    output logic [15:0]       o_height,
    output logic              o_in_range
);
    import hmtbs_pkg::*;

    t_meta              r_m3;
    logic signed [20:0] r_top4, r_bot4;
    logic [7:0]         r_fz4;
    logic               r_inr4;
    logic [15:0]        r_height;
    logic               r_inr;

    logic signed [10:0] bl, br, tl, tr;
    logic signed [9:0]  fx, nfx, fz, nfz;
    logic signed [20:0] n_top, n_bot;
    logic signed [30:0] h;
    logic [30:0]        q;
    logic [15:0]        n_height;

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_m3 <= i_meta;
        end
        if (i_en4) begin
            r_top4 <= n_top;
            r_bot4 <= n_bot;
            r_fz4  <= r_m3.fz;
            r_inr4 <= r_m3.in_range;
        end
        if (i_eno) begin
            r_height <= n_height;
            r_inr    <= r_inr4;
        end
    end

    always_comb begin
        bl  = $signed({3'b000, i_rdata[{r_m3.z0p, r_m3.x0p}]});
        br  = $signed({3'b000, i_rdata[{r_m3.z0p, r_m3.x1p}]});
        tl  = $signed({3'b000, i_rdata[{r_m3.z1p, r_m3.x0p}]});
        tr  = $signed({3'b000, i_rdata[{r_m3.z1p, r_m3.x1p}]});
        fx  = $signed({2'b00, r_m3.fx});
        fz  = $signed({2'b00, r_m3.fz});
        nfx = 10'sd256 - fx;
        // corner opposite the point's triangle becomes a planar estimate
        if (r_m3.rev) begin
            if (fz >= fx) begin
                br = bl + (tr - tl);
            end else begin
                tl = tr + (bl - br);
            end
        end else begin
            if (fz < nfx) begin
                tr = tl + (br - bl);
            end else begin
                bl = tl + (br - tr);
            end
        end
        n_top = tl * 21'(nfx) + tr * 21'(fx);
        n_bot = bl * 21'(nfx) + br * 21'(fx);
    end

    always_comb begin
        nfz = 10'sd256 - $signed({2'b00, r_fz4});
        h   = r_bot4 * 31'(nfz) + r_top4 * 31'($signed({2'b00, r_fz4}));
        q   = 31'(h + 31'sd128) >> 8;
        if (!r_inr4 || h < 0) begin
            n_height = 16'd0;
        end else if (q > 31'd65535) begin
            n_height = 16'hFFFF;
        end else begin
            n_height = q[15:0];
        end
    end

    assign o_height   = r_height;
    assign o_in_range = r_inr;
endmodule

FILE: dv/hm_tb_pkg.sv
package hm_tb_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int STORE_COLS = 512;
    localparam int STORE_ROWS = 512;

endpackage

FILE: dv/heightmap_triangle_bilinear_sampler_checker.sv
module heightmap_triangle_bilinear_sampler_checker
    import hmtbs_pkg::*;
    import hm_tb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_cmd,
    input  logic [8:0]         i_load_col,
    input  logic [8:0]         i_load_row,
    input  logic [7:0]         i_pixel,
    input  logic signed [31:0] i_world_x,
    input  logic signed [31:0] i_world_z,
    input  logic               i_reverse_quad,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [15:0]        o_height,
    input  logic               o_in_range,
    output int                 pending,
    output int                 failures
);

    typedef struct {
        logic [15:0] height;
        logic        in_range;
    } t_height_result;

    logic [7:0]     heights [0:STORE_COLS*STORE_ROWS-1];
    logic [9:0]     cfg_width;
    logic [9:0]     cfg_length;
    logic [23:0]    cfg_inv_x;
    logic [23:0]    cfg_inv_z;
    t_height_result expected_heights [$];

    assign pending = expected_heights.size();

    function automatic int unsigned dim_used(logic [9:0] v, int unsigned maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int corner(int unsigned x, int unsigned z);
        return int'(heights[z*STORE_COLS + x]);
    endfunction

    function automatic t_height_result predict_height(logic signed [31:0] wx,
                                                      logic signed [31:0] wz,
                                                      logic rev);
        t_height_result r;
        int unsigned w, l, x0, z0, x1, z1;
        longint px, pz, gx, gz, top, bot, h, q;
        int fx, fz, bl, br, tl, tr;
        w = dim_used(cfg_width, STORE_COLS);
        l = dim_used(cfg_length, STORE_ROWS);
        px = longint'(wx) * longint'({40'd0, cfg_inv_x});
        pz = longint'(wz) * longint'({40'd0, cfg_inv_z});
        gx = px >>> 16;
        gz = pz >>> 16;
        r.height = '0;
        r.in_range = 1'b0;
        if (px < 0 || pz < 0 || (gx >> 8) >= w || (gz >> 8) >= l) return r;
        x0 = gx >> 8;
        z0 = gz >> 8;
        fx = gx & 255;
        fz = gz & 255;
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        z1 = (z0 + 1 < l) ? z0 + 1 : l - 1;
        bl = corner(x0, z0);
        br = corner(x1, z0);
        tl = corner(x0, z1);
        tr = corner(x1, z1);
        // far corner of the cell gets the plane through the other three
        if (rev) begin
            if (fz >= fx) br = bl + (tr - tl);
            else tl = tr + (bl - br);
        end else begin
            if (fz < 256 - fx) tr = tl + (br - bl);
            else bl = tl + (br - tr);
        end
        top = longint'(tl) * (256 - fx) + longint'(tr) * fx;
        bot = longint'(bl) * (256 - fx) + longint'(br) * fx;
        h = bot * (256 - fz) + top * fz;
        if (h < 0) q = 0;
        else begin
            q = (h + 128) >> 8;
            if (q > 65535) q = 65535;
        end
        r.height = q[15:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    initial failures = 0;

    always @(posedge i_clk) begin
        t_height_result exp_r;
        int unsigned l;
        if (!i_rst_n) begin
            cfg_width <= 10'd512;
            cfg_length <= 10'd512;
            cfg_inv_x <= 24'd65536;
            cfg_inv_z <= 24'd65536;
            expected_heights.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_heights.size() == 0) begin
                    $error("result transfer with no query pending: height %0d in_range %0d",
                           o_height, o_in_range);
                    failures++;
                end else begin
                    exp_r = expected_heights.pop_front();
                    if (o_height !== exp_r.height) begin
                        $error("height: expected %0d, got %0d", exp_r.height, o_height);
                        failures++;
                    end
                    if (o_in_range !== exp_r.in_range) begin
                        $error("in_range: expected %0d, got %0d", exp_r.in_range, o_in_range);
                        failures++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (i_cmd == CMD_LOAD) begin
                    l = dim_used(cfg_length, STORE_ROWS);
                    if (i_load_col < dim_used(cfg_width, STORE_COLS) && i_load_row < l)
                        heights[(l - 1 - i_load_row)*STORE_COLS + i_load_col] = i_pixel;
                end else begin
                    expected_heights.push_back(
                        predict_height(i_world_x, i_world_z, i_reverse_quad));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_MAP_WIDTH:  cfg_width <= pwdata[9:0];
                    REG_MAP_LENGTH: cfg_length <= pwdata[9:0];
                    REG_INV_X:      cfg_inv_x <= pwdata[23:0];
                    REG_INV_Z:      cfg_inv_z <= pwdata[23:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: dv/heightmap_triangle_bilinear_sampler_tb.sv
module heightmap_triangle_bilinear_sampler_tb;
    import hmtbs_pkg::*;
    import hm_tb_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               i_valid, o_ready, i_cmd, i_reverse_quad;
    logic [8:0]         i_load_col, i_load_row;
    logic [7:0]         i_pixel;
    logic signed [31:0] i_world_x, i_world_z;
    logic               o_valid, i_ready, o_in_range;
    logic [15:0]        o_height;
    int                 pending, failures;

    int unsigned map_w, map_l;
    logic [23:0] scale_x, scale_z;
    bit          steady;
    int          result_stall;
    int          item_count;

    heightmap_triangle_bilinear_sampler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(i_cmd),
        .i_load_col(i_load_col), .i_load_row(i_load_row), .i_pixel(i_pixel),
        .i_world_x(i_world_x), .i_world_z(i_world_z), .i_reverse_quad(i_reverse_quad),
        .o_valid(o_valid), .i_ready(i_ready), .o_height(o_height), .o_in_range(o_in_range)
    );

    heightmap_triangle_bilinear_sampler_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(i_cmd),
        .i_load_col(i_load_col), .i_load_row(i_load_row), .i_pixel(i_pixel),
        .i_world_x(i_world_x), .i_world_z(i_world_z), .i_reverse_quad(i_reverse_quad),
        .o_valid(o_valid), .i_ready(i_ready), .o_height(o_height), .o_in_range(o_in_range),
        .pending(pending), .failures(failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side back-pressure, redrawn after every result transfer
    initial begin
        result_stall = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_stall > 0) begin
                i_ready <= 1'b0;
                result_stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk)
        if (o_valid && i_ready) result_stall = steady ? 0 : $urandom_range(0, 4);

    task automatic send_item(logic cmd, logic [8:0] col, logic [8:0] row, logic [7:0] pix,
                             logic [31:0] wx, logic [31:0] wz, logic rev);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd <= cmd;
        i_load_col <= col;
        i_load_row <= row;
        i_pixel <= pix;
        i_world_x <= wx;
        i_world_z <= wz;
        i_reverse_quad <= rev;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic query(logic [31:0] wx, logic [31:0] wz, logic rev);
        send_item(CMD_QUERY, 9'($urandom), 9'($urandom), 8'($urandom), wx, wz, rev);
    endtask

    // waits out in-flight loads too, which give no result
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_map(logic [9:0] w, logic [9:0] l, logic [23:0] sx, logic [23:0] sz);
        drain();
        reg_write(REG_MAP_WIDTH, 32'(w));
        reg_write(REG_MAP_LENGTH, 32'(l));
        reg_write(REG_INV_X, 32'(sx));
        reg_write(REG_INV_Z, 32'(sz));
        map_w = (w < 2) ? 2 : (w > STORE_COLS) ? STORE_COLS : w;
        map_l = (l < 2) ? 2 : (l > STORE_ROWS) ? STORE_ROWS : l;
        scale_x = sx;
        scale_z = sz;
    endtask

    // writes every row of the given column span
    task automatic fill_cols(int unsigned c_lo, int unsigned c_hi);
        for (int r = 0; r < map_l; r++)
            for (int c = c_lo; c <= c_hi; c++)
                send_item(CMD_LOAD, 9'(c), 9'(r), 8'($urandom), $urandom, $urandom,
                          1'($urandom));
    endtask

    // every entry of the map in use is written before any query reads it
    task automatic fill_map();
        fill_cols(0, map_w - 1);
    endtask

    // world coordinate aimed near the map, sometimes anywhere at all
    function automatic logic [31:0] aim(int unsigned dim, logic [23:0] inv);
        longint t, wv;
        if (inv == 0 || $urandom_range(0, 3) == 0) return $urandom;
        t = longint'($urandom_range(0, dim*256 + 63)) - 32;
        wv = (t * 65536) / longint'({40'd0, inv});
        if (wv > 64'sd2147483647 || wv < -64'sd2147483648) return $urandom;
        return wv[31:0];
    endfunction

    initial begin
        logic [9:0] w, l;
        logic [23:0] sx, sz;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_cmd = CMD_LOAD; i_load_col = '0; i_load_row = '0;
        i_pixel = '0; i_world_x = '0; i_world_z = '0; i_reverse_quad = 1'b0;
        steady = 1'b0;
        item_count = 0;
        map_w = STORE_COLS; map_l = STORE_ROWS;
        scale_x = 24'd65536; scale_z = 24'd65536;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset map: nothing loaded yet, so only points off the map
        query(32'h8000_0000, 32'h0000_0000, 1'b0);
        query(32'h0000_0000, 32'hffff_ffff, 1'b1);
        query(32'h7fff_ffff, 32'h0000_0100, 1'b0);
        query(32'h0002_0000, 32'h7fff_ffff, 1'b1);
        query(32'hffff_ff00, 32'h8000_0000, 1'b0);

        // widest map, shortest length, both saturated; columns 0 to 4 and the
        // last two are loaded, covering every column the queries below touch
        set_map(10'd1023, 10'd0, 24'd65536, 24'd65536);
        fill_cols(0, 4);
        fill_cols(map_w - 2, map_w - 1);
        query(32'd0, 32'd0, 1'b0);
        query(32'd0, 32'd0, 1'b1);
        query(32'h0001_ffff, 32'h0000_01ff, 1'b0);   // last column and row clamp
        query(32'h0001_ffff, 32'h0000_01ff, 1'b1);
        query(32'h0000_0280, 32'h0000_0040, 1'b0);
        query(32'h0000_0240, 32'h0000_0080, 1'b1);
        query(32'h0000_0340, 32'h0000_00f0, 1'b0);
        query(32'h0000_03f0, 32'h0000_0010, 1'b1);
        query(32'h0002_0000, 32'h0000_0000, 1'b0);   // one past last column
        query(32'h0000_0000, 32'h0000_0200, 1'b1);   // one past last row

        // smallest map, zero and largest reciprocal scales
        set_map(10'd2, 10'd2, 24'd0, 24'hff_ffff);
        fill_map();
        send_item(CMD_LOAD, 9'd2, 9'd0, 8'hff, '0, '0, 1'b0);   // ignored
        send_item(CMD_LOAD, 9'd0, 9'h1ff, 8'h00, '0, '0, 1'b0); // ignored
        query(32'h7fff_ffff, 32'd0, 1'b0);
        query(32'h8000_0000, 32'd1, 1'b1);
        query(32'd5, 32'd1, 1'b0);
        query(32'd0, 32'd2, 1'b1);

        while (item_count < 1050) begin
            w = 10'($urandom_range(1, 16));
            l = 10'($urandom_range(1, 16));
            case ($urandom_range(0, 5))
                0: begin sx = 24'd0; sz = 24'($urandom); end
                1: begin sx = 24'($urandom); sz = 24'($urandom); end
                default: begin
                    sx = 24'($urandom_range(4096, 262144));
                    sz = 24'($urandom_range(4096, 262144));
                end
            endcase
            set_map(w, l, sx, sz);
            steady = ($urandom_range(0, 3) == 0);
            fill_map();
            repeat (80) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(CMD_LOAD, 9'($urandom_range(0, map_w + 2)),
                              9'($urandom_range(0, map_l + 2)), 8'($urandom),
                              $urandom, $urandom, 1'($urandom));
                end else begin
                    query(aim(map_w, scale_x), aim(map_l, scale_z), 1'($urandom));
                end
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
